[sv/bilinear_image_sampler_top_defines.svh]
// Assertion macros used by the bilinear image sampler RTL.
`ifndef BILINEAR_IMAGE_SAMPLER_TOP_DEFINES_SVH
`define BILINEAR_IMAGE_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst is high.
`define BIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst is high.
`define BIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bis_pkg.sv]
// Shared types and constants of the bilinear image sampler.
package bis_pkg;

  // Fixed field widths of the stream payload
  localparam int COORD_W    = 17;
  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 2;
  localparam int POS_W      = 8;
  localparam int SIZE_W     = 9;
  localparam int COUNT_W    = 3;
  localparam int RESULT_CAP = 4;

  // Input tdata layout, lowest bit first
  localparam int CHAN_LSB   = 0;
  localparam int COL_LSB    = CHAN_LSB + CHAN_W;
  localparam int ROW_LSB    = COL_LSB + POS_W;
  localparam int PIX_LSB    = ROW_LSB + POS_W;
  localparam int X_LSB      = PIX_LSB + SAMPLE_W;
  localparam int Y_LSB      = X_LSB + COORD_W;
  localparam int IN_DATA_W  = 72;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_HEIGHT,
    REG_IMAGE_WIDTH,
    REG_CHANNEL_COUNT,
    REG_FILL_VALUE
  } cfg_reg_t;

  localparam logic [SIZE_W-1:0]          HEIGHT_RST = 9'd256;
  localparam logic [SIZE_W-1:0]          WIDTH_RST  = 9'd256;
  localparam logic [COUNT_W-1:0]         COUNT_RST  = 3'd1;
  localparam logic signed [SAMPLE_W-1:0] FILL_RST   = 16'sd0;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Item kinds carried in s_axis_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Neighbor order: bit 0 selects the right column, bit 1 the lower row
  localparam logic [1:0] NBR_FIRST = 2'd0;
  localparam logic [1:0] NBR_LAST  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_EMIT
  } seq_state_t;

  // Read issued to the store, tagged with its neighbor slot
  typedef struct packed {
    logic       vld;
    logic [1:0] nbr;
  } mac_ctl_t;

  // One result handed to the output register
  typedef struct packed {
    logic              vld;
    logic              fill;
    logic [CHAN_W-1:0] chan;
    logic              last;
  } res_push_t;

endpackage

[sv/bis_store.sv]
// Single-port-write, single-port-read image sample memory with registered read.
module bis_store #(
  parameter int ADDR_W = 18,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Store one sample
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one sample, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/bis_mac.sv]
// Weighted accumulation of four neighbor samples, rounding and saturation.
module bis_mac
  import bis_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 8,
  parameter int PIXEL_BITS      = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctl_t                   ctl,
  input  logic [COORD_FRAC_BITS-1:0] fx,
  input  logic [COORD_FRAC_BITS-1:0] fy,
  input  logic [PIXEL_BITS-1:0]      rd_data,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam int F     = COORD_FRAC_BITS;
  localparam int WGT_W = 2 * F + 1;
  localparam int ACC_W = PIXEL_BITS + 2 * F + 2;
  localparam int R_W   = ACC_W - 2 * F;
  localparam int EXT_W = (R_W > SAMPLE_W + 1) ? R_W : SAMPLE_W + 1;

  localparam logic [F:0]                ONE    = {1'b1, {F{1'b0}}};
  localparam logic [ACC_W-1:0]          HALF   = ACC_W'(1) << (2 * F - 1);
  localparam logic signed [EXT_W-1:0]   SAT_HI = EXT_W'(32767);
  localparam logic signed [EXT_W-1:0]   SAT_LO = EXT_W'(-32768);

  logic [F:0]                wx;
  logic [F:0]                wy;
  logic [2*F+1:0]            wprod;
  logic [WGT_W-1:0]          wgt;
  logic                      a_vld;
  logic [1:0]                a_nbr;
  logic signed [ACC_W-1:0]   prod;
  logic                      b_vld;
  logic [1:0]                b_nbr;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [R_W-1:0]     r;
  logic signed [EXT_W-1:0]   r_ext;

  // Pick the 1-D weights of the neighbor being read
  always_comb begin
    wx    = ctl.nbr[0] ? {1'b0, fx} : ONE - {1'b0, fx};
    wy    = ctl.nbr[1] ? {1'b0, fy} : ONE - {1'b0, fy};
    wprod = wx * wy;
  end

  // Stage A: weight lines up with the sample coming out of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    a_nbr <= ctl.nbr;
    wgt   <= wprod[WGT_W-1:0];
  end

  // Stage B: sample times weight
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_nbr <= a_nbr;
    prod  <= $signed(rd_data) * $signed({1'b0, wgt});
  end

  // Stage C: accumulate, flag the sum once the fourth product is in
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_vld && (b_nbr == NBR_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld) begin
      acc <= (b_nbr == NBR_FIRST) ? prod : acc + prod;
    end
  end

  // Round half up, drop the weight scale, clamp to the sample range
  always_comb begin
    acc_rnd = acc + $signed(HALF);
    r       = acc_rnd[ACC_W-1:2*F];
    r_ext   = EXT_W'(r);
    if (r_ext > SAT_HI) begin
      result = SAMPLE_MAX;
    end else if (r_ext < SAT_LO) begin
      result = SAMPLE_MIN;
    end else begin
      result = r_ext[SAMPLE_W-1:0];
    end
  end

endmodule

[sv/bis_seq.sv]
// Item sequencer: stores samples, decodes queries and walks the neighbor reads.
`include "bilinear_image_sampler_top_defines.svh"

module bis_seq
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH       = 256,
  parameter int MAX_HEIGHT      = 256,
  parameter int MAX_CHANNELS    = 4,
  parameter int COORD_FRAC_BITS = 8,
  parameter int PIXEL_BITS      = 16,
  localparam int XW     = $clog2(MAX_WIDTH),
  localparam int RW     = $clog2(MAX_HEIGHT),
  localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int ADDR_W = CW + RW + XW
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic [CHAN_W-1:0]          in_channel,
  input  logic [POS_W-1:0]           in_column,
  input  logic [POS_W-1:0]           in_row,
  input  logic [SAMPLE_W-1:0]        in_pixel,
  input  logic [COORD_W-1:0]         in_x,
  input  logic [COORD_W-1:0]         in_y,
  input  logic [SIZE_W-1:0]          image_height,
  input  logic [SIZE_W-1:0]          image_width,
  input  logic [COUNT_W-1:0]         channel_count,
  input  logic                       out_free,
  input  logic                       mac_done,
  output logic                       wr_en,
  output logic [ADDR_W-1:0]          wr_addr,
  output logic [PIXEL_BITS-1:0]      wr_data,
  output logic                       rd_en,
  output logic [ADDR_W-1:0]          rd_addr,
  output mac_ctl_t                   ctl,
  output logic [COORD_FRAC_BITS-1:0] fx,
  output logic [COORD_FRAC_BITS-1:0] fy,
  output res_push_t                  res
);

  localparam int F      = COORD_FRAC_BITS;
  localparam int CH_CAP = (MAX_CHANNELS < RESULT_CAP) ? MAX_CHANNELS : RESULT_CAP;

  localparam logic [COORD_W-1:0] MAX_W_C = COORD_W'(MAX_WIDTH);
  localparam logic [COORD_W-1:0] MAX_H_C = COORD_W'(MAX_HEIGHT);
  localparam logic [COUNT_W-1:0] CAP_C   = COUNT_W'(CH_CAP);

  seq_state_t           state;
  seq_state_t           state_next;
  logic [1:0]           nbr;
  logic [1:0]           nbr_next;
  logic [CHAN_W-1:0]    chan;
  logic [CHAN_W-1:0]    chan_next;
  logic [COUNT_W-1:0]   nchan;
  logic                 chan_is_last;
  logic                 qfill;
  logic [XW-1:0]        col0;
  logic [XW-1:0]        col1;
  logic [RW-1:0]        row0;
  logic [RW-1:0]        row1;

  logic [COORD_W-1:0]   xi;
  logic [COORD_W-1:0]   yi;
  logic [COORD_W-1:0]   w_eff;
  logic [COORD_W-1:0]   h_eff;
  logic [F-1:0]         fx_in;
  logic [F-1:0]         fy_in;
  logic                 x_in;
  logic                 x_edge;
  logic                 y_in;
  logic                 y_edge;
  logic                 q_ok;
  logic [XW-1:0]        col0_in;
  logic [XW-1:0]        col1_in;
  logic [RW-1:0]        row0_in;
  logic [RW-1:0]        row1_in;
  logic [COUNT_W-1:0]   n_in;
  logic                 wr_in_range;

  // Decode the query point against the clamped image size
  always_comb begin
    xi     = in_x >> F;
    yi     = in_y >> F;
    fx_in  = in_x[F-1:0];
    fy_in  = in_y[F-1:0];
    w_eff  = (COORD_W'(image_width) > MAX_W_C) ? MAX_W_C : COORD_W'(image_width);
    h_eff  = (COORD_W'(image_height) > MAX_H_C) ? MAX_H_C : COORD_W'(image_height);
    x_in   = (xi != '0) && (xi < w_eff);
    x_edge = (xi != '0) && (xi == w_eff) && (fx_in == '0);
    y_in   = (yi != '0) && (yi < h_eff);
    y_edge = (yi != '0) && (yi == h_eff) && (fy_in == '0);
    q_ok   = (x_in || x_edge) && (y_in || y_edge);
    // On an edge the far neighbor repeats the near one; its weight is zero
    col0_in = XW'(xi - COORD_W'(1));
    row0_in = RW'(yi - COORD_W'(1));
    col1_in = x_in ? XW'(xi) : col0_in;
    row1_in = y_in ? RW'(yi) : row0_in;
    n_in    = (channel_count > CAP_C) ? CAP_C : channel_count;
  end

  // Sample write path, taken only from idle so it never meets a read burst
  always_comb begin
    wr_in_range = (int'(in_channel) < MAX_CHANNELS) && (int'(in_column) < MAX_WIDTH) &&
                  (int'(in_row) < MAX_HEIGHT);
    wr_en   = in_valid && in_ready && (in_op == OP_WRITE) && wr_in_range;
    wr_addr = {CW'(in_channel), RW'(in_row), XW'(in_column)};
    wr_data = PIXEL_BITS'({{PIXEL_BITS{in_pixel[SAMPLE_W-1]}}, in_pixel});
  end

  assign chan_is_last = (({1'b0, chan} + COUNT_W'(1)) == nchan);

  // Next state and outputs
  always_comb begin
    state_next = state;
    nbr_next   = nbr;
    chan_next  = chan;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    res.vld    = 1'b0;
    res.fill   = qfill;
    res.chan   = chan;
    res.last   = chan_is_last;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_op == OP_QUERY) && (n_in != '0)) begin
          chan_next  = '0;
          nbr_next   = NBR_FIRST;
          state_next = q_ok ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        rd_en    = 1'b1;
        nbr_next = nbr + 2'd1;
        if (nbr == NBR_LAST) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          res.vld = 1'b1;
          if (chan_is_last) begin
            state_next = ST_IDLE;
          end else begin
            chan_next  = chan + 1'b1;
            nbr_next   = NBR_FIRST;
            state_next = qfill ? ST_EMIT : ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      nbr   <= NBR_FIRST;
      chan  <= '0;
    end else begin
      state <= state_next;
      nbr   <= nbr_next;
      chan  <= chan_next;
    end
  end

  // Hold the decoded query while its channels are worked off
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      nchan <= n_in;
      qfill <= !q_ok;
      col0  <= col0_in;
      col1  <= col1_in;
      row0  <= row0_in;
      row1  <= row1_in;
      fx    <= fx_in;
      fy    <= fy_in;
    end
  end

  // Neighbor address and tag for the accumulator
  assign rd_addr = {CW'(chan), nbr[1] ? row1 : row0, nbr[0] ? col1 : col0};
  assign ctl.vld = rd_en;
  assign ctl.nbr = nbr;

  `BIS_ASSERT_IMP(a_done_in_wait, mac_done, state == ST_WAIT, "sum ready outside wait state")
  `BIS_ASSERT_IMP(a_push_slot_free, res.vld, out_free, "result pushed into a full output slot")
  `BIS_ASSERT_NXT(a_last_to_idle, res.vld && res.last, state == ST_IDLE, "no return to idle")
  `BIS_ASSERT_NXT(a_burst_end, state == ST_READ && nbr == NBR_LAST, state == ST_WAIT,
                  "read burst overran four neighbors")

endmodule

[sv/bilinear_image_sampler_top.sv]
// Top level of the bilinear image sampler: config registers, core and output register.
//
//   channel  | direction | carries
//   ---------+-----------+-------------------------------------------------------
//   s_axis   | in        | sample writes (tuser = 0) and point queries (tuser = 1)
//   m_axis   | out       | one interpolated value per channel, tlast on the final one
//   cfg      | in        | image_height, image_width, channel_count, fill_value
//
// A write is taken in the idle state. A query walks its n channels: per channel four
// reads on the single store read port, the multiply and accumulate pipe, and a push
// into the output register. A query off the image makes no reads and pushes the fill
// value for each channel. Reset clears control state only; the store holds nothing
// defined until written and gets no clearing pass. A stalled m_axis holds a channel in
// the emit state; the next input transaction is taken while the final result waits.
module bilinear_image_sampler_top
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH       = 256,
  parameter int MAX_HEIGHT      = 256,
  parameter int MAX_CHANNELS    = 4,
  parameter int COORD_FRAC_BITS = 8,
  parameter int PIXEL_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // channel, column, row, pixel_value, x_coord, y_coord, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // interp_value
  output logic [SAMPLE_W-1:0]   m_axis_tdata,
  // out_channel
  output logic [CHAN_W-1:0]     m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W = CW + RW + XW;

  logic [SIZE_W-1:0]            image_height;
  logic [SIZE_W-1:0]            image_width;
  logic [COUNT_W-1:0]           channel_count;
  logic signed [SAMPLE_W-1:0]   fill_value;

  logic                         out_free;
  logic                         mac_done;
  logic signed [SAMPLE_W-1:0]   mac_result;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [PIXEL_BITS-1:0]        wr_data;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic [PIXEL_BITS-1:0]        rd_data;
  mac_ctl_t                     ctl;
  logic [COORD_FRAC_BITS-1:0]   fx;
  logic [COORD_FRAC_BITS-1:0]   fy;
  res_push_t                    res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_height  <= HEIGHT_RST;
      image_width   <= WIDTH_RST;
      channel_count <= COUNT_RST;
      fill_value    <= FILL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_IMAGE_HEIGHT:  image_height  <= cfg_wdata[SIZE_W-1:0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_wdata[SIZE_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_wdata[COUNT_W-1:0];
        REG_FILL_VALUE:    fill_value    <= cfg_wdata;
      endcase
    end
  end

  bis_seq #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_CHANNELS    (MAX_CHANNELS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .PIXEL_BITS      (PIXEL_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_op         (s_axis_tuser[0]),
    .in_channel    (s_axis_tdata[CHAN_LSB +: CHAN_W]),
    .in_column     (s_axis_tdata[COL_LSB +: POS_W]),
    .in_row        (s_axis_tdata[ROW_LSB +: POS_W]),
    .in_pixel      (s_axis_tdata[PIX_LSB +: SAMPLE_W]),
    .in_x          (s_axis_tdata[X_LSB +: COORD_W]),
    .in_y          (s_axis_tdata[Y_LSB +: COORD_W]),
    .image_height  (image_height),
    .image_width   (image_width),
    .channel_count (channel_count),
    .out_free      (out_free),
    .mac_done      (mac_done),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .ctl           (ctl),
    .fx            (fx),
    .fy            (fy),
    .res           (res)
  );

  bis_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (PIXEL_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bis_mac #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .PIXEL_BITS      (PIXEL_BITS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .fx      (fx),
    .fy      (fy),
    .rd_data (rd_data),
    .done    (mac_done),
    .result  (mac_result)
  );

  // Output register: free when empty or being taken this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.vld) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      m_axis_tdata <= res.fill ? fill_value : mac_result;
      m_axis_tuser <= res.chan;
      m_axis_tlast <= res.last;
    end
  end

endmodule
